// ===== design/pct_pkg.sv =====
// ----------------------------------------------------------------------------
// pct_pkg
// Shared types and constants for the permutation cycle type block.
// ----------------------------------------------------------------------------
package pct_pkg;

  localparam int unsigned IMG_W      = 6;   // image value width
  localparam int unsigned IMG_RAM_W  = IMG_W + 1;  // visited mark above the image
  localparam int unsigned IMG_DEPTH  = 64;  // image store entries
  localparam int unsigned HIST_DEPTH = 65;  // histogram entries, lengths 0..64
  localparam int unsigned HIST_AW    = 7;
  localparam int unsigned CNT_W      = 7;   // holds 0..64
  localparam int unsigned MULT_W     = 7;

  // controller states, one-hot
  typedef enum logic [7:0] {
    S_LOAD   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_FOLLOW = 8'b0000_0100,
    S_HRD    = 8'b0000_1000,
    S_HWR    = 8'b0001_0000,
    S_ORD    = 8'b0010_0000,
    S_OLD    = 8'b0100_0000,
    S_ERR    = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic                 we;
    logic [IMG_W-1:0]     waddr;
    logic [IMG_RAM_W-1:0] wdata;
    logic                 re;
    logic [IMG_W-1:0]     raddr;
  } img_req_t;

  typedef struct packed {
    logic              we;
    logic [HIST_AW-1:0] waddr;
    logic [MULT_W-1:0]  wdata;
    logic              re;
    logic [HIST_AW-1:0] raddr;
  } hist_req_t;

  typedef struct packed {
    logic [CNT_W-1:0]  len;
    logic [MULT_W-1:0] mult;
    logic              bad;
    logic              last;
  } result_t;

endpackage

// ===== design/pct_ram.sv =====
// ----------------------------------------------------------------------------
// pct_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pct_ctrl.sv =====
// ----------------------------------------------------------------------------
// pct_ctrl
// Load, cycle walk, histogram update and result scan sequencer.
// ----------------------------------------------------------------------------
module pct_ctrl #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [pct_pkg::IMG_W-1:0]    in_img_i,
  input  logic                         in_last_i,
  output pct_pkg::img_req_t            img_req_o,
  input  logic [pct_pkg::IMG_RAM_W-1:0] img_rdata_i,
  output pct_pkg::hist_req_t           hist_req_o,
  input  logic [pct_pkg::MULT_W-1:0]   hist_rdata_i,
  output logic                         res_valid_o,
  output pct_pkg::result_t             res_o,
  input  logic                         res_ready_i
);

  import pct_pkg::*;

  localparam int unsigned CAP = (MAX_ENTRIES < IMG_DEPTH) ? MAX_ENTRIES : IMG_DEPTH;
  localparam logic [CNT_W-1:0] CAP_C   = CNT_W'(CAP);
  localparam logic [CNT_W-1:0] TOP_LEN = CNT_W'(HIST_DEPTH - 1);

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;      // loaded entries
  logic                    ovf_q, ovf_d;
  logic [IMG_W-1:0]        maxi_q, maxi_d;    // largest stored image
  logic [HIST_DEPTH-1:0]   hvld_q, hvld_d;    // histogram entry nonzero
  logic [CNT_W-1:0]        idx_q, idx_d;      // scan start index
  logic [CNT_W-1:0]        len_q, len_d;      // walk length / output length
  logic [CNT_W-1:0]        minl_q, minl_d;    // shortest length seen
  logic [IMG_W-1:0]        cur_q, cur_d;      // entry whose read is in flight
  logic                    fwd_q, fwd_d;      // read hit the entry marked alongside
  logic                    bad_w;
  logic                    rd_vis_w;
  logic [IMG_W-1:0]        rd_img_w;

  assign in_ready_o = (state_q == S_LOAD);
  assign rd_vis_w   = img_rdata_i[IMG_W];
  assign rd_img_w   = img_rdata_i[IMG_W-1:0];

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    maxi_d     = maxi_q;
    hvld_d     = hvld_q;
    idx_d      = idx_q;
    len_d      = len_q;
    minl_d     = minl_q;
    cur_d      = cur_q;
    fwd_d      = 1'b0;
    bad_w      = 1'b0;
    img_req_o  = '0;
    hist_req_o = '0;
    res_valid_o = 1'b0;
    res_o      = '0;

    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          if (cnt_q < CAP_C) begin
            // loading also clears the visited mark of the entry
            img_req_o.we    = 1'b1;
            img_req_o.waddr = cnt_q[IMG_W-1:0];
            img_req_o.wdata = {1'b0, in_img_i};
            cnt_d           = cnt_q + CNT_W'(1);
            if (in_img_i > maxi_q) begin
              maxi_d = in_img_i;
            end
          end else begin
            ovf_d = 1'b1;
          end
          if (in_last_i) begin
            bad_w = ovf_d || ({1'b0, maxi_d} >= cnt_d);
            idx_d = '0;
            state_d = bad_w ? S_ERR : S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (idx_q == cnt_q) begin
          len_d   = TOP_LEN;
          state_d = S_ORD;
        end else begin
          img_req_o.re    = 1'b1;
          img_req_o.raddr = idx_q[IMG_W-1:0];
          cur_d   = idx_q[IMG_W-1:0];
          len_d   = '0;
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_FOLLOW;
        end
      end

      S_FOLLOW: begin
        // entry cur_q is on the read port; mark it and read its image
        if (rd_vis_w || fwd_q) begin
          state_d = (len_q == '0) ? S_SCAN : S_HRD;
        end else begin
          img_req_o.we    = 1'b1;
          img_req_o.waddr = cur_q;
          img_req_o.wdata = {1'b1, rd_img_w};
          img_req_o.re    = 1'b1;
          img_req_o.raddr = rd_img_w;
          cur_d           = rd_img_w;
          fwd_d           = (rd_img_w == cur_q);  // RAM returns the old mark
          len_d           = len_q + CNT_W'(1);
        end
      end

      S_HRD: begin
        hist_req_o.re    = 1'b1;
        hist_req_o.raddr = len_q;
        if (len_q < minl_q) begin
          minl_d = len_q;
        end
        state_d = S_HWR;
      end

      S_HWR: begin
        hist_req_o.we    = 1'b1;
        hist_req_o.waddr = len_q;
        hist_req_o.wdata = hvld_q[len_q] ? hist_rdata_i + MULT_W'(1) : MULT_W'(1);
        hvld_d[len_q]    = 1'b1;
        state_d          = S_SCAN;
      end

      S_ORD: begin
        // skip empty lengths without touching the RAM
        if (hvld_q[len_q]) begin
          hist_req_o.re    = 1'b1;
          hist_req_o.raddr = len_q;
          state_d          = S_OLD;
        end else if (len_q == '0) begin
          state_d = S_LOAD;
        end else begin
          len_d = len_q - CNT_W'(1);
        end
      end

      S_OLD: begin
        res_valid_o = 1'b1;
        res_o.len   = len_q;
        res_o.mult  = hist_rdata_i;
        res_o.last  = (len_q == minl_q);
        if (res_ready_i) begin
          len_d   = len_q - CNT_W'(1);
          state_d = res_o.last ? S_LOAD : S_ORD;
        end
      end

      S_ERR: begin
        res_valid_o = 1'b1;
        res_o.bad   = 1'b1;
        res_o.last  = 1'b1;
        if (res_ready_i) begin
          state_d = S_LOAD;
        end
      end

      default: begin
        state_d = S_LOAD;
      end
    endcase

    // fresh start for the next permutation
    if (state_d == S_LOAD && state_q != S_LOAD) begin
      cnt_d  = '0;
      ovf_d  = 1'b0;
      maxi_d = '0;
      hvld_d = '0;
      minl_d = '1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      maxi_q  <= '0;
      hvld_q  <= '0;
      idx_q   <= '0;
      len_q   <= '0;
      minl_q  <= '1;
      cur_q   <= '0;
      fwd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      maxi_q  <= maxi_d;
      hvld_q  <= hvld_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      minl_q  <= minl_d;
      cur_q   <= cur_d;
      fwd_q   <= fwd_d;
    end
  end

endmodule

// ===== design/permutation_cycle_type_top.sv =====
// ----------------------------------------------------------------------------
// permutation_cycle_type_top
// Cycle type of a streamed permutation, emitted as (length, count) pairs.
// ----------------------------------------------------------------------------
// Load: one input word per cycle, written straight into the image RAM; words past capacity only set overflow.
// Analysis after the last word: a walk from each unvisited entry that marks
//   every entry it reaches and counts the walk length into the histogram,
//   then a downward scan of the histogram that emits one pair per nonzero
//   length through the output register. Input is held off during analysis.
// Error result: the controller goes from the last word to the error state.
// Reset: async active low; clears controller, histogram valid flops and output
//   valid. RAM contents are not reset: visited marks sit beside each image and
//   are cleared by the load; per-entry valid flops stand in for clearing the
//   histogram.
module permutation_cycle_type_top #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [5:0] image_value, [7:6] zero
  input  logic        s_axis_tlast_i,   // last_entry
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [6:0] cycle_length, [13:7] multiplicity, [15:14] zero
  output logic        m_axis_tuser_o,   // bad_entry
  output logic        m_axis_tlast_o    // last_pair
);

  import pct_pkg::*;

  img_req_t             img_req;
  hist_req_t            hist_req;
  logic [IMG_RAM_W-1:0] img_rdata;
  logic [MULT_W-1:0]    hist_rdata;
  logic                 res_valid;
  logic                 res_ready;
  result_t              res;

  // output stage
  logic               out_valid_q;
  result_t            out_q;

  // image store, visited mark on top: one write per loaded word,
  // one read and one mark write per walk step
  pct_ram #(
    .WIDTH (IMG_RAM_W),
    .DEPTH (IMG_DEPTH)
  ) u_img_ram (
    .clk_i   (clk_i),
    .we_i    (img_req.we),
    .waddr_i (img_req.waddr),
    .wdata_i (img_req.wdata),
    .re_i    (img_req.re),
    .raddr_i (img_req.raddr),
    .rdata_o (img_rdata)
  );

  // length histogram: read-modify-write per cycle found, then scanned downward
  pct_ram #(
    .WIDTH (MULT_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_req.we),
    .waddr_i (hist_req.waddr),
    .wdata_i (hist_req.wdata),
    .re_i    (hist_req.re),
    .raddr_i (hist_req.raddr),
    .rdata_o (hist_rdata)
  );

  pct_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_img_i     (s_axis_tdata_i[IMG_W-1:0]),
    .in_last_i    (s_axis_tlast_i),
    .img_req_o    (img_req),
    .img_rdata_i  (img_rdata),
    .hist_req_o   (hist_req),
    .hist_rdata_i (hist_rdata),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  // the output register takes a word when empty or draining; else the controller stalls
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q.mult, out_q.len};
  assign m_axis_tuser_o  = out_q.bad;
  assign m_axis_tlast_o  = out_q.last;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams maps into the cycle type block and checks every (length, count)
// word it returns against a scoreboard that walks the same map. Covers
// bijections, maps that are not bijective, out-of-range images and
// overflowing loads, under three idling mixes and one long output hold-off.
// ----------------------------------------------------------------------------

// Scoreboard: keeps its own copy of the loaded map and the pairs it yields.
class cycle_type_scoreboard;
  localparam int unsigned StoreDepth = 64;
  localparam int unsigned HistTop    = 64;
  localparam int unsigned MaxPairs   = 10;

  int unsigned       capacity;
  logic [5:0]        image_map [StoreDepth];
  int unsigned       loaded;
  bit                overflowed;
  pct_pkg::result_t  pairs_q [$];
  int unsigned       errors;

  function new(int unsigned max_entries);
    capacity   = (max_entries < StoreDepth) ? max_entries : StoreDepth;
    loaded     = 0;
    overflowed = 1'b0;
    errors     = 0;
  endfunction

  // Accepted input word: store it; on the final entry, predict the pairs.
  function void note_entry(logic [5:0] img, logic last);
    bit               seen [StoreDepth];
    int unsigned      hist [HistTop+1];
    int unsigned      len, nxt, distinct, emitted;
    bit               bad;
    pct_pkg::result_t r;
    if (loaded < capacity) begin
      image_map[loaded] = img;
      loaded++;
    end else begin
      overflowed = 1'b1;
    end
    if (!last) return;

    bad = overflowed;
    for (int i = 0; i < loaded; i++)
      if (image_map[i] >= loaded) bad = 1'b1;

    if (bad) begin
      r.len  = '0;
      r.mult = '0;
      r.bad  = 1'b1;
      r.last = 1'b1;
      pairs_q = {pairs_q, r};
    end else begin
      foreach (seen[i]) seen[i] = 1'b0;
      foreach (hist[i]) hist[i] = 0;
      // walk from each unvisited index until a visited one comes up
      for (int i = 0; i < loaded; i++) begin
        if (!seen[i]) begin
          seen[i] = 1'b1;
          len = 1;
          nxt = image_map[i];
          while (!seen[nxt]) begin
            seen[nxt] = 1'b1;
            len++;
            nxt = image_map[nxt];
          end
          if (len <= HistTop) hist[len]++;
        end
      end
      distinct = 0;
      for (int l = HistTop; l >= 1; l--)
        if (hist[l] != 0 && distinct < MaxPairs) distinct++;
      emitted = 0;
      for (int l = HistTop; l >= 1; l--) begin
        if (hist[l] != 0 && emitted < MaxPairs) begin
          r.len  = l[6:0];
          r.mult = hist[l][6:0];
          r.bad  = 1'b0;
          r.last = (emitted == distinct - 1);
          pairs_q = {pairs_q, r};
          emitted++;
        end
      end
    end
    loaded     = 0;
    overflowed = 1'b0;
  endfunction

  // Accepted output word: compare with the oldest predicted pair.
  function void check_pair(pct_pkg::result_t got);
    pct_pkg::result_t want;
    if (pairs_q.size() == 0) begin
      $error("unexpected pair: cycle_length %0d multiplicity %0d bad_entry %0d last_pair %0d",
             got.len, got.mult, got.bad, got.last);
      errors++;
      return;
    end
    want = pairs_q.pop_front();
    if (got.len !== want.len) begin
      $error("cycle_length: expected %0d, actual %0d", want.len, got.len);
      errors++;
    end
    if (got.mult !== want.mult) begin
      $error("multiplicity: expected %0d, actual %0d", want.mult, got.mult);
      errors++;
    end
    if (got.bad !== want.bad) begin
      $error("bad_entry: expected %0d, actual %0d", want.bad, got.bad);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last_pair: expected %0d, actual %0d", want.last, got.last);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return pairs_q.size();
  endfunction
endclass

module tb_top;

  localparam int unsigned MAX_ENTRIES  = 64;
  localparam int unsigned RANDOM_ITEMS = 120;
  localparam int unsigned HOLD_CYCLES  = 600;     // long output hold-off
  localparam int unsigned DRAIN_CYCLES = 500;     // > worst analysis time
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // kinds of map the random part builds
  typedef enum int {
    MAP_PERM,      // bijection
    MAP_ANY,       // images in range, not necessarily bijective
    MAP_RANGE,     // one image at or above the entry count
    MAP_OVER       // more entries than the store holds
  } map_kind_e;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT signals; every input has a known value at time 0
  // --------------------------------------------------------------------------
  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        s_tvalid  = 1'b0;
  logic [7:0]  s_tdata   = '0;
  logic        s_tlast   = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  always #5 clk_i = ~clk_i;

  // idling mix, percent of cycles; set by the stimulus, read by the drivers
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;

  // hold-off handshake: stimulus bumps requests, receiver serves them
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;

  int unsigned items_sent = 0;
  int unsigned cycle_cnt  = 0;

  cycle_type_scoreboard sb = new(MAX_ENTRIES);

  permutation_cycle_type_top #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [5:0] image_value, [7:6] zero
    .s_axis_tlast_i  (s_tlast),   // last_entry
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // [6:0] cycle_length, [13:7] multiplicity, [15:14] zero
    .m_axis_tuser_o  (m_tuser),   // bad_entry
    .m_axis_tlast_o  (m_tlast)    // last_pair
  );

  // --------------------------------------------------------------------------
  // Monitors: sample both handshakes at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_tready)
      sb.note_entry(s_tdata[5:0], s_tlast);
  end

  always @(posedge clk_i) begin
    pct_pkg::result_t got;
    if (rst_ni && m_tvalid && m_tready) begin
      got.len  = m_tdata[6:0];
      got.mult = m_tdata[13:7];
      got.bad  = m_tuser;
      got.last = m_tlast;
      sb.check_pair(got);
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready at the falling edge, or a counted hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_tready = 1'b0;
    end else if (hold_left > 0) begin
      m_tready = 1'b0;
      hold_left--;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES - 1;
      m_tready    = 1'b0;
    end else begin
      m_tready = ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks; each is entered and left at a falling edge
  // --------------------------------------------------------------------------
  // One word: optional idle cycles, then hold valid until accepted.
  task automatic send_word(logic [5:0] img, logic last);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tdata  = {2'b00, img};
    s_tlast  = last;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Whole map, tlast on its final entry.
  task automatic send_map(logic [5:0] m [$]);
    foreach (m[i]) send_word(m[i], i == m.size() - 1);
    items_sent += m.size();
  endtask

  // Back-to-back cycles of lengths lo..hi on consecutive indices.
  task automatic send_cycles(int unsigned lo, int unsigned hi);
    logic [5:0]  m [$];
    int unsigned base;
    base = 0;
    for (int unsigned l = lo; l <= hi; l++) begin
      for (int unsigned k = 0; k < l; k++)
        m = {m, 6'(base + (k + 1) % l)};
      base += l;
    end
    send_map(m);
  endtask

  task automatic send_random_map(int unsigned n, map_kind_e kind);
    logic [5:0]  m [$];
    logic [5:0]  t;
    int unsigned pick;
    for (int unsigned i = 0; i < n; i++) m = {m, 6'(i)};
    case (kind)
      MAP_PERM: begin
        for (int unsigned i = n - 1; i > 0; i--) begin
          pick    = $urandom_range(i);
          t       = m[i];
          m[i]    = m[pick];
          m[pick] = t;
        end
      end
      MAP_ANY: begin
        foreach (m[i]) m[i] = 6'($urandom_range(n - 1));
      end
      MAP_RANGE: begin
        foreach (m[i]) m[i] = 6'($urandom_range(n - 1));
        m[$urandom_range(n - 1)] = 6'($urandom_range(63, n));
      end
      default: begin
        foreach (m[i]) m[i] = 6'($urandom_range(63));
      end
    endcase
    send_map(m);
  endtask

  // Random map, mostly small well-formed permutations.
  task automatic send_random_case();
    int unsigned roll, n;
    map_kind_e   kind;
    roll = $urandom_range(99);
    if (roll < 4)       kind = MAP_OVER;
    else if (roll < 14) kind = MAP_RANGE;
    else if (roll < 30) kind = MAP_ANY;
    else                kind = MAP_PERM;
    roll = $urandom_range(99);
    if (roll < 78)      n = $urandom_range(12, 1);
    else if (roll < 94) n = $urandom_range(40, 13);
    else                n = $urandom_range(64, 41);
    if (kind == MAP_OVER) n = $urandom_range(68, 65);
    else if (kind == MAP_RANGE && n == 64) n = 63;
    send_random_map(n, kind);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [5:0]  m [$];
    int unsigned goal;

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: sender sparse, receiver mostly stalled
    snd_idle_pct = 8;
    rcv_idle_pct = 88;
    send_cycles(1, 1);              // single fixed point
    m = {6'd1};                     // single entry pointing past the end
    send_map(m);
    m = {6'd63, 6'd0};              // top image value, out of range
    send_map(m);
    send_cycles(2, 2);              // one transposition
    m = {6'd1, 6'd1, 6'd1};         // not bijective: tail into a fixed point
    send_map(m);
    m = {6'd1, 6'd2, 6'd0, 6'd0};   // entries 0..2 loop, entry 3 hangs on them as a tail
    send_map(m);
    send_cycles(1, 10);             // ten distinct lengths, most pairs
    send_cycles(64, 64);            // one full-length cycle, fills the store
    send_random_map(65, MAP_OVER);  // one entry too many

    // random, phase 1: sender sparse, receiver mostly stalled
    goal = items_sent + RANDOM_ITEMS / 3;
    while (items_sent < goal) send_random_case();

    // phase 2: the other way round
    snd_idle_pct = 88;
    rcv_idle_pct = 8;
    goal = items_sent + RANDOM_ITEMS / 3;
    while (items_sent < goal) send_random_case();

    // phase 3: no idling, opened by a long output hold-off so the block
    // backs up into its input while words keep coming
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_requests++;
    goal = items_sent + RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3);
    while (items_sent < goal) send_random_case();

    s_tvalid = 1'b0;
    s_tlast  = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
